/* design/irc_strip_pkg.sv */
// Package for the IRC formatting-code stripper: strip modes, result beat type,
// code constants and character-class helpers. No dependencies.
package irc_strip_pkg;

  localparam int unsigned LenWidth   = 12;
  localparam int unsigned ByteWidth  = 8;
  localparam int unsigned HexMax     = 6;
  localparam int unsigned QueueDepth = 4;

  localparam logic [LenWidth-1:0]  MaxOutLenReset = 12'd487;
  localparam logic [ByteWidth-1:0] CodeColour     = 8'h03;
  localparam logic [ByteWidth-1:0] CodeHexColour  = 8'h04;
  localparam logic [ByteWidth-1:0] FirstPrint     = 8'h20;
  localparam logic [ByteWidth-1:0] CharComma      = 8'h2C;

  typedef enum logic [2:0] {
    MODE_NORMAL,
    MODE_FG_FIRST,
    MODE_FG_SECOND,
    MODE_AFTER_FG,
    MODE_COMMA_HELD,
    MODE_BG_SECOND,
    MODE_HEX
  } strip_mode_t;

  typedef struct packed {
    logic [ByteWidth-1:0] data;
    logic                 has_byte;
    logic                 last;
  } result_t;

  function automatic logic is_dec(input logic [ByteWidth-1:0] c);
    return (c >= 8'h30) && (c <= 8'h39);
  endfunction

  function automatic logic is_hex(input logic [ByteWidth-1:0] c);
    logic [ByteWidth-1:0] l;
    l = c | 8'h20;
    return is_dec(c) || ((l >= 8'h61) && (l <= 8'h66));
  endfunction

endpackage

/* design/irc_format_code_stripper_core.sv */
// Top level of the IRC formatting-code stripper: input register, strip-mode
// machine and a small result queue. Depends on irc_strip_pkg.

// One raw chat-line byte enters per beat, in_last on the final byte. Color
// codes (0x03 with up to two foreground digits and an optional ",bg" pair),
// hex color codes (0x04 with up to six hex digits) and every other control
// byte below 0x20 are removed; printable bytes pass through until max_out_len
// bytes have been emitted on the line. Each line ends with exactly one result
// beat carrying out_last; if the final byte leaves nothing to keep, that beat
// is an empty marker with has_byte low. Rate: one input byte per clock while
// the queue has room for two beats. A byte is held in the input register,
// where the mode machine decodes it, and is then written into a four-entry
// result queue from which the output is read. A comma held after a color
// foreground and released by a following non-digit yields two result beats
// for one input byte; the queue absorbs that while the output drains one beat
// per cycle while out_ready is high. The input register hands its byte on
// only while the queue has room for two beats. max_out_len resets to 487; the user
// must write it through cfg_we/cfg_wdata only while idle; the block does not enforce this.
module irc_format_code_stripper_core
  import irc_strip_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  // configuration
  input  logic                 cfg_we,
  input  logic [LenWidth-1:0]  cfg_wdata,
  // input channel
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [ByteWidth-1:0] in_byte,
  input  logic                 in_last,
  // result channel
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [ByteWidth-1:0] out_byte,
  output logic                 has_byte,
  output logic                 out_last
);

  localparam int unsigned PtrWidth = $clog2(QueueDepth);
  localparam int unsigned CntWidth = $clog2(QueueDepth + 1);

  // configuration register
  logic [LenWidth-1:0] max_out_len;

  // input register
  logic                 inq_valid;
  logic [ByteWidth-1:0] inq_byte;
  logic                 inq_last;

  // mode machine state
  strip_mode_t          mode, mode_next;
  logic [2:0]           hex_cnt, hex_cnt_next;
  logic [LenWidth-1:0]  emitted_count, emitted_count_next;

  // decode of the current byte
  logic                 comma_release;
  logic                 plain_path;
  logic                 emit_comma_first;
  logic                 emit_byte;
  logic                 emit_comma_end;
  logic [LenWidth-1:0]  cnt1;
  logic [LenWidth-1:0]  cnt2;
  strip_mode_t          plain_mode;

  // results of one byte
  result_t              res0, res1;
  logic [1:0]           res_num;

  // result queue
  result_t              queue [QueueDepth];
  logic [PtrWidth-1:0]  wr_ptr, rd_ptr;
  logic [CntWidth-1:0]  q_count;
  logic                 proc_fire;
  logic                 out_fire;

  // Advance the byte out of the input register only when the queue can take
  // the worst case of two beats.
  assign proc_fire = inq_valid && (q_count <= CntWidth'(QueueDepth - 2));
  assign in_ready  = !inq_valid || proc_fire;
  assign out_valid = (q_count != '0);
  assign out_fire  = out_valid && out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      max_out_len <= MaxOutLenReset;
    end else if (cfg_we) begin
      max_out_len <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      inq_valid <= 1'b0;
    end else if (in_ready) begin
      inq_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      inq_byte <= in_byte;
      inq_last <= in_last;
    end
  end

  // Where a byte falls back to plain text handling, it lands in this mode.
  always_comb begin
    if (inq_byte == CodeColour) begin
      plain_mode = MODE_FG_FIRST;
    end else if (inq_byte == CodeHexColour) begin
      plain_mode = MODE_HEX;
    end else begin
      plain_mode = MODE_NORMAL;
    end
  end

  // Next state of the mode machine. The line end returns everything to the
  // reset state, abandoning any open code.
  always_comb begin
    mode_next          = mode;
    hex_cnt_next       = hex_cnt;
    plain_path         = 1'b0;
    comma_release      = 1'b0;
    case (mode)
      MODE_FG_FIRST: begin
        if (is_dec(inq_byte)) mode_next = MODE_FG_SECOND;
        else                  plain_path = 1'b1;
      end
      MODE_FG_SECOND: begin
        if (is_dec(inq_byte))             mode_next = MODE_AFTER_FG;
        else if (inq_byte == CharComma)   mode_next = MODE_COMMA_HELD;
        else                              plain_path = 1'b1;
      end
      MODE_AFTER_FG: begin
        if (inq_byte == CharComma) mode_next = MODE_COMMA_HELD;
        else                       plain_path = 1'b1;
      end
      MODE_COMMA_HELD: begin
        if (is_dec(inq_byte)) begin
          mode_next = MODE_BG_SECOND;
        end else begin
          comma_release = 1'b1;
          plain_path    = 1'b1;
        end
      end
      MODE_BG_SECOND: begin
        if (is_dec(inq_byte)) mode_next = MODE_NORMAL;
        else                  plain_path = 1'b1;
      end
      MODE_HEX: begin
        if ((hex_cnt < 3'(HexMax)) && is_hex(inq_byte)) begin
          if (hex_cnt == 3'(HexMax - 1)) begin
            mode_next    = MODE_NORMAL;
            hex_cnt_next = '0;
          end else begin
            hex_cnt_next = hex_cnt + 3'd1;
          end
        end else begin
          hex_cnt_next = '0;
          plain_path   = 1'b1;
        end
      end
      default: begin
        plain_path = 1'b1;
      end
    endcase
    if (plain_path) begin
      mode_next = plain_mode;
      if (inq_byte == CodeHexColour) hex_cnt_next = '0;
    end
  end

  // Emission decisions against the line limit, then the result beats.
  always_comb begin
    emit_comma_first = comma_release && (emitted_count < max_out_len);
    cnt1             = emitted_count + LenWidth'(emit_comma_first);
    emit_byte        = plain_path && (inq_byte >= FirstPrint) && (cnt1 < max_out_len);
    cnt2             = cnt1 + LenWidth'(emit_byte);
    // a comma still held at line end goes out as text
    emit_comma_end   = inq_last && (mode_next == MODE_COMMA_HELD) && (cnt2 < max_out_len);
    emitted_count_next = cnt2;
  end

  always_comb begin
    res0    = '0;
    res1    = '0;
    res_num = 2'd0;
    if (emit_comma_first) begin
      res0.data     = CharComma;
      res0.has_byte = 1'b1;
      res_num       = 2'd1;
      if (emit_byte) begin
        res1.data     = inq_byte;
        res1.has_byte = 1'b1;
        res1.last     = inq_last;
        res_num       = 2'd2;
      end else begin
        res0.last = inq_last;
      end
    end else if (emit_byte) begin
      res0.data     = inq_byte;
      res0.has_byte = 1'b1;
      res0.last     = inq_last;
      res_num       = 2'd1;
    end else if (emit_comma_end) begin
      res0.data     = CharComma;
      res0.has_byte = 1'b1;
      res0.last     = 1'b1;
      res_num       = 2'd1;
    end else if (inq_last) begin
      // empty end marker
      res0.last = 1'b1;
      res_num   = 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode          <= MODE_NORMAL;
      hex_cnt       <= '0;
      emitted_count <= '0;
    end else if (proc_fire) begin
      if (inq_last) begin
        mode          <= MODE_NORMAL;
        hex_cnt       <= '0;
        emitted_count <= '0;
      end else begin
        mode          <= mode_next;
        hex_cnt       <= hex_cnt_next;
        emitted_count <= emitted_count_next;
      end
    end
  end

  // Result queue: push zero, one or two beats, pop one.
  always_ff @(posedge clk) begin
    if (proc_fire && (res_num != 2'd0)) begin
      queue[wr_ptr] <= res0;
    end
    if (proc_fire && (res_num == 2'd2)) begin
      queue[wr_ptr + PtrWidth'(1)] <= res1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr  <= '0;
      rd_ptr  <= '0;
      q_count <= '0;
    end else begin
      if (proc_fire) begin
        wr_ptr <= wr_ptr + PtrWidth'(res_num);
      end
      if (out_fire) begin
        rd_ptr <= rd_ptr + PtrWidth'(1);
      end
      q_count <= q_count + (proc_fire ? CntWidth'(res_num) : '0)
                         - CntWidth'(out_fire);
    end
  end

  assign out_byte = queue[rd_ptr].data;
  assign has_byte = queue[rd_ptr].has_byte;
  assign out_last = queue[rd_ptr].last;

  // Checks
  a_queue_bound: assert property (@(posedge clk) disable iff (rst)
    q_count <= CntWidth'(QueueDepth))
    else $error("result queue overflow");

  a_marker_is_last: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !has_byte) |-> out_last)
    else $error("empty result beat without line end");

  a_line_end_clears: assert property (@(posedge clk) disable iff (rst)
    (proc_fire && inq_last) |=> ((mode == MODE_NORMAL) && (emitted_count == '0)
                                 && (hex_cnt == '0)))
    else $error("state not cleared after line end");

  a_hex_bound: assert property (@(posedge clk) disable iff (rst)
    hex_cnt < 3'(HexMax))
    else $error("hex digit count out of range");

  a_two_beats_only_on_release: assert property (@(posedge clk) disable iff (rst)
    (proc_fire && (res_num == 2'd2)) |-> (mode == MODE_COMMA_HELD))
    else $error("two result beats outside comma release");

endmodule
